FILE: design/symbol_clock_recovery_dll_unit_macros.svh
// Assertion macros shared by the symbol clock recovery design files.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef SYMBOL_CLOCK_RECOVERY_DLL_UNIT_MACROS_SVH
`define SYMBOL_CLOCK_RECOVERY_DLL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define SCRDLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define SCRDLL_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SCRDLL_ASSERT(label, prop, msg)
`define SCRDLL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: design/scrdll_pkg.sv
// Shared types, widths and register codes for the symbol clock recovery unit.
// No dependencies.
`timescale 1ns / 1ps

package scrdll_pkg;

    localparam int PHASE_BITS_DEFAULT = 15;
    localparam int REG_BITS           = 15;
    localparam int SYMBOL_BITS        = 8;
    localparam int ERROR_BITS         = 16;
    localparam int COUNT_BITS         = 16;
    localparam int CFG_INDEX_BITS     = 1;

    localparam logic [REG_BITS-1:0] PHASE_STEP_RESET   = 15'd2048;
    localparam logic [REG_BITS-1:0] TARGET_PHASE_RESET = 15'd16384;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_PHASE = 1'd1;

    typedef struct packed {
        logic [REG_BITS-1:0] phase_step;
        logic [REG_BITS-1:0] target_phase;
    } scrdll_cfg_t;

    typedef struct packed {
        logic                          capture;
        logic                          edge_seen;
        logic signed [ERROR_BITS-1:0]  phase_error;
        logic [COUNT_BITS-1:0]         samples_since_edge;
    } scrdll_result_t;

endpackage

FILE: design/scrdll_cfg_regs.sv
// Configuration register file: phase step and target phase.
// Depends on scrdll_pkg.
`timescale 1ns / 1ps

module scrdll_cfg_regs
    import scrdll_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data,
    output scrdll_cfg_t               cfg
);

    logic [REG_BITS-1:0] phase_step_reg;
    logic [REG_BITS-1:0] target_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= PHASE_STEP_RESET;
            target_phase_reg <= TARGET_PHASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_TARGET_PHASE: target_phase_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.phase_step   = phase_step_reg;
    assign cfg.target_phase = target_phase_reg;

endmodule

FILE: design/scrdll_phase_loop.sv
// Phase accumulator loop: edge detection, phase pull, error hold and edge counter.
// Depends on scrdll_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "symbol_clock_recovery_dll_unit_macros.svh"

module scrdll_phase_loop
    import scrdll_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [SYMBOL_BITS-1:0] symbol_value,
    input  scrdll_cfg_t            cfg,
    output scrdll_result_t         result
);

    // Difference width covers both the accumulator and the 16-bit error.
    localparam int DIFF_BITS = (PHASE_BITS > ERROR_BITS) ? PHASE_BITS : ERROR_BITS;
    // Sum width is one bit above the wider addend so the carry is kept.
    localparam int SUM_BITS  = ((PHASE_BITS > REG_BITS) ? PHASE_BITS : REG_BITS) + 1;

    logic [PHASE_BITS-1:0]        phase_acc_reg,    phase_acc_next;
    logic [SYMBOL_BITS-1:0]       prev_symbol_reg,  prev_symbol_next;
    logic signed [ERROR_BITS-1:0] held_error_reg,   held_error_next;
    logic [COUNT_BITS-1:0]        edge_counter_reg, edge_counter_next;

    logic                         edge_hit;
    logic [DIFF_BITS-1:0]         diff;
    logic signed [ERROR_BITS-1:0] err;
    logic signed [ERROR_BITS-1:0] adj;
    logic [DIFF_BITS-1:0]         pulled;
    logic [PHASE_BITS-1:0]        phase_base;
    logic [SUM_BITS-1:0]          sum;

    always_comb
    begin
        edge_hit = (symbol_value != prev_symbol_reg);

        diff = DIFF_BITS'(phase_acc_reg) - DIFF_BITS'(cfg.target_phase);
        err  = $signed(diff[ERROR_BITS-1:0]);
        // Arithmetic shift rounds toward minus infinity.
        adj  = err >>> 1;
        pulled = DIFF_BITS'(phase_acc_reg) - DIFF_BITS'(adj);

        phase_base = edge_hit ? pulled[PHASE_BITS-1:0] : phase_acc_reg;
        sum = SUM_BITS'(phase_base) + SUM_BITS'(cfg.phase_step);

        phase_acc_next    = sum[PHASE_BITS-1:0];
        prev_symbol_next  = symbol_value;
        held_error_next   = edge_hit ? err : held_error_reg;
        edge_counter_next = edge_hit ? COUNT_BITS'(1) : (edge_counter_reg + COUNT_BITS'(1));

        result.capture            = (sum[SUM_BITS-1:PHASE_BITS] != '0);
        result.edge_seen          = edge_hit;
        result.phase_error        = held_error_next;
        result.samples_since_edge = edge_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            prev_symbol_reg  <= '0;
            held_error_reg   <= '0;
            edge_counter_reg <= '0;
        end
        else if (fire)
        begin
            phase_acc_reg    <= phase_acc_next;
            prev_symbol_reg  <= prev_symbol_next;
            held_error_reg   <= held_error_next;
            edge_counter_reg <= edge_counter_next;
        end
    end

    `SCRDLL_ASSERT(a_edge_restarts_count, (fire && edge_hit) |=> (edge_counter_reg == COUNT_BITS'(1)), "edge did not restart the sample count")
    `SCRDLL_ASSERT(a_count_advances, (fire && !edge_hit) |=> (edge_counter_reg == COUNT_BITS'($past(edge_counter_reg) + COUNT_BITS'(1))), "sample count did not advance by one")
    `SCRDLL_ASSERT(a_state_holds_idle, !fire |=> ($stable(phase_acc_reg) && $stable(prev_symbol_reg) && $stable(held_error_reg)), "loop state moved without an item")

endmodule

FILE: design/symbol_clock_recovery_dll_unit.sv
// Path: an accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; the phase accumulator, edge check and
// pull all settle in the add, subtract and compare logic between the input and result registers.
// Reset: asynchronous, active low; clears the loop state and valid flags and returns
// phase_step to 2048 and target_phase to 16384.
// Depends on scrdll_pkg, scrdll_cfg_regs, scrdll_phase_loop and the assertion macros.
`timescale 1ns / 1ps
`include "symbol_clock_recovery_dll_unit_macros.svh"

module symbol_clock_recovery_dll_unit
    import scrdll_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration write port.
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [REG_BITS-1:0]          cfg_data,

    // Input symbol channel.
    input  logic                         symbol_valid,
    output logic                         symbol_stall,
    input  logic [SYMBOL_BITS-1:0]       symbol_value,

    // Result channel.
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         capture,
    output logic                         edge_seen,
    output logic signed [ERROR_BITS-1:0] phase_error,
    output logic [COUNT_BITS-1:0]        samples_since_edge
);

    // The design is a two-register pipeline. An accepted item first lands in the
    // input register. When the result register is empty, or its item is being taken
    // in the same cycle, the phase loop processes the held item, updates its state
    // and the result is written to the result register. The input register is freed
    // in that same cycle, so a new item can be accepted while a finished result
    // still waits at the output.

    scrdll_cfg_t            cfg;
    scrdll_result_t         loop_result;

    logic                   in_valid_reg;
    logic [SYMBOL_BITS-1:0] in_symbol_reg;
    logic                   out_valid_reg;
    scrdll_result_t         out_result_reg;

    logic                   fire;
    logic                   in_take;

    // The loop may step when there is an item held and the result register has room.
    assign fire         = in_valid_reg && (!out_valid_reg || !result_stall);
    assign symbol_stall = in_valid_reg && !fire;
    assign in_take      = symbol_valid && !symbol_stall;

    scrdll_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scrdll_phase_loop #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_loop
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .symbol_value (in_symbol_reg),
        .cfg          (cfg),
        .result       (loop_result)
    );

    // Valid flags carry reset; the payload registers do not need it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_symbol_reg <= symbol_value;
        end
        if (fire)
        begin
            out_result_reg <= loop_result;
        end
    end

    assign result_valid       = out_valid_reg;
    assign capture            = out_result_reg.capture;
    assign edge_seen          = out_result_reg.edge_seen;
    assign phase_error        = out_result_reg.phase_error;
    assign samples_since_edge = out_result_reg.samples_since_edge;

    // Input is held back only when both registers are full and the output is stalled.
    `SCRDLL_ASSERT(a_stall_only_when_full, symbol_stall |-> (in_valid_reg && out_valid_reg && result_stall), "input stalled with room in the pipeline")
    // A result appears only after a held item has been processed.
    `SCRDLL_ASSERT(a_result_from_item, $rose(result_valid) |-> $past(in_valid_reg), "result appeared without a held item")
    // A waiting result is never overwritten while it is still stalled.
    `SCRDLL_ASSERT_NEVER(a_no_overwrite, fire && out_valid_reg && result_stall, "stalled result overwritten")

endmodule
